// ----- design/cidr_pkg.sv -----
// Shared types, character codes and result codes for the IPv4 CIDR text analyzer.
// Used by the line accumulator, the result decoder, the top level and the checker.
package cidr_pkg;

    // Field widths and limits.
    localparam int CHAR_W        = 8;
    localparam int VALUE_W       = 10;
    localparam int COUNT_W       = 5;
    localparam int INDEX_W       = 3;
    localparam int NUM_OCTETS    = 4;
    localparam int ADDR_W        = 32;
    localparam int PREFIX_W      = 6;
    localparam int MAX_LINE_CHARS_DEF = 18;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // Character codes of interest.
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Result status codes; the first failing check wins.
    typedef enum logic [3:0] {
        ST_OK       = 4'd0,
        ST_BAD_CHAR = 4'd1,
        ST_TOO_LONG = 4'd2,
        ST_FORMAT   = 4'd3,
        ST_OCTET1   = 4'd4,
        ST_OCTET2   = 4'd5,
        ST_OCTET3   = 4'd6,
        ST_OCTET4   = 4'd7,
        ST_PREFIX   = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        CLASS_A    = 3'd0,
        CLASS_B    = 3'd1,
        CLASS_C    = 3'd2,
        CLASS_D    = 3'd3,
        CLASS_E    = 3'd4,
        CLASS_NONE = 3'd5
    } addr_class_t;

    typedef enum logic [2:0] {
        TYPE_PUBLIC    = 3'd0,
        TYPE_PRIVATE   = 3'd1,
        TYPE_LOCALHOST = 3'd2,
        TYPE_MULTICAST = 3'd3,
        TYPE_BROADCAST = 3'd4
    } addr_type_t;

    // Running state of the current text line.
    typedef struct packed {
        logic [INDEX_W-1:0]                   field_index;
        logic                                 digit_seen;
        logic [VALUE_W-1:0]                   field_value;
        logic [NUM_OCTETS-1:0][VALUE_W-1:0]   octet_store;
        logic [COUNT_W-1:0]                   char_count;
        logic                                 bad_char_flag;
    } line_state_t;

    // One decoded result.
    typedef struct packed {
        status_t              status;
        logic [ADDR_W-1:0]    address;
        logic [PREFIX_W-1:0]  prefix_len;
        logic [ADDR_W-1:0]    network_addr;
        logic [ADDR_W-1:0]    host_addr;
        addr_class_t          addr_class;
        addr_type_t           addr_type;
    } result_t;

endpackage

// ----- design/cidr_line_acc.sv -----
// Line accumulator: parses one character per step into field values and counters.
// Depends on cidr_pkg for the state struct and character codes.
module cidr_line_acc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [cidr_pkg::CHAR_W-1:0] char_code,
    output cidr_pkg::line_state_t       line_state
);
    import cidr_pkg::*;

    line_state_t                state_reg;
    line_state_t                state_next;
    logic [VALUE_W+3:0]         acc_value;
    logic [3:0]                 digit_val;
    logic [COUNT_W-1:0]         count_bumped;

    // Decimal accumulate of the next digit, before saturation.
    assign digit_val    = 4'(char_code - CHAR_ZERO);
    assign acc_value    = ({4'd0, state_reg.field_value} << 3)
                        + ({4'd0, state_reg.field_value} << 1)
                        + {(VALUE_W)'(0), digit_val};
    assign count_bumped = (state_reg.char_count < COUNT_MAX)
                        ? state_reg.char_count + 1'b1 : state_reg.char_count;

    // Next-state logic for one character.
    always_comb begin
        state_next = state_reg;
        if (step_en) begin
            priority if (char_code == CHAR_NL) begin
                state_next = '0;
            end else if (char_code == CHAR_DOT || char_code == CHAR_SLASH) begin
                if (state_reg.field_index < INDEX_W'(NUM_OCTETS)) begin
                    state_next.octet_store[state_reg.field_index[1:0]] =
                        state_reg.field_value;
                end
                if (state_reg.field_index < INDEX_MAX) begin
                    state_next.field_index = state_reg.field_index + 1'b1;
                end
                state_next.field_value = '0;
                state_next.digit_seen  = 1'b0;
                state_next.char_count  = count_bumped;
            end else if (char_code == CHAR_SPACE) begin
                state_next = state_reg;
            end else if (char_code == CHAR_ZERO && !state_reg.digit_seen) begin
                state_next = state_reg;
            end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
                state_next.field_value = (acc_value > {4'd0, VALUE_MAX})
                                       ? VALUE_MAX : acc_value[VALUE_W-1:0];
                state_next.digit_seen  = 1'b1;
                state_next.char_count  = count_bumped;
            end else begin
                state_next.bad_char_flag = 1'b1;
            end
        end
    end

    // State register; cleared by reset and after every newline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    assign line_state = state_reg;

endmodule

// ----- design/cidr_result_dec.sv -----
// Result decoder: checks a finished line and derives address, mask, class and type.
// Purely combinational; depends on cidr_pkg for the state and result structs.
module cidr_result_dec #(
    parameter int MAX_LINE_CHARS = cidr_pkg::MAX_LINE_CHARS_DEF
) (
    input  cidr_pkg::line_state_t line_state,
    output cidr_pkg::result_t     result
);
    import cidr_pkg::*;

    status_t              status;
    logic [VALUE_W-1:0]   prefix;
    logic [7:0]           o0;
    logic [7:0]           o1;
    logic [7:0]           o2;
    logic [7:0]           o3;
    logic [ADDR_W-1:0]    addr;
    logic [ADDR_W-1:0]    mask;
    addr_class_t          cls;
    addr_type_t           typ;

    assign prefix = line_state.field_value;

    // Status checks in priority order.
    always_comb begin
        priority if (line_state.bad_char_flag) begin
            status = ST_BAD_CHAR;
        end else if (line_state.char_count > COUNT_W'(MAX_LINE_CHARS)) begin
            status = ST_TOO_LONG;
        end else if (line_state.field_index != INDEX_W'(NUM_OCTETS)) begin
            status = ST_FORMAT;
        end else if (line_state.octet_store[0] > VALUE_W'(255)) begin
            status = ST_OCTET1;
        end else if (line_state.octet_store[1] > VALUE_W'(255)) begin
            status = ST_OCTET2;
        end else if (line_state.octet_store[2] > VALUE_W'(255)) begin
            status = ST_OCTET3;
        end else if (line_state.octet_store[3] > VALUE_W'(255)) begin
            status = ST_OCTET4;
        end else if (prefix > VALUE_W'(32)) begin
            status = ST_PREFIX;
        end else begin
            status = ST_OK;
        end
    end

    // Address and prefix mask; octets are in range whenever status is ok.
    assign o0   = line_state.octet_store[0][7:0];
    assign o1   = line_state.octet_store[1][7:0];
    assign o2   = line_state.octet_store[2][7:0];
    assign o3   = line_state.octet_store[3][7:0];
    assign addr = {o0, o1, o2, o3};
    assign mask = ~({ADDR_W{1'b1}} >> prefix[PREFIX_W-1:0]);

    // Class by the leading bits of the first octet; loopback has no class.
    always_comb begin
        priority if (o0 >= 8'd240) begin
            cls = CLASS_E;
        end else if (o0 >= 8'd224) begin
            cls = CLASS_D;
        end else if (o0 >= 8'd192) begin
            cls = CLASS_C;
        end else if (o0 >= 8'd128) begin
            cls = CLASS_B;
        end else if (o0 != 8'd127) begin
            cls = CLASS_A;
        end else begin
            cls = CLASS_NONE;
        end
    end

    // Address type; the first matching rule wins.
    always_comb begin
        priority if (o0 == 8'd255 && o1 == 8'd255 && o2 == 8'd255 && o3 == 8'd255
                     && prefix == VALUE_W'(32)) begin
            typ = TYPE_BROADCAST;
        end else if (o0 >= 8'd224 && o0 <= 8'd239) begin
            typ = TYPE_MULTICAST;
        end else if (o0 == 8'd127) begin
            typ = TYPE_LOCALHOST;
        end else if ((o0 == 8'd10 && prefix == VALUE_W'(8))
                  || (o0 == 8'd192 && o1 == 8'd168 && prefix == VALUE_W'(16))
                  || (o0 == 8'd172 && prefix == VALUE_W'(12)
                      && o1 >= 8'd16 && o1 <= 8'd31)) begin
            typ = TYPE_PRIVATE;
        end else begin
            typ = TYPE_PUBLIC;
        end
    end

    // Everything but the status reads as zero on a failed line.
    always_comb begin
        result        = '0;
        result.status = status;
        if (status == ST_OK) begin
            result.address      = addr;
            result.prefix_len   = prefix[PREFIX_W-1:0];
            result.network_addr = addr & mask;
            result.host_addr    = addr & ~mask;
            result.addr_class   = cls;
            result.addr_type    = typ;
        end
    end

endmodule

// ----- design/ipv4_cidr_text_analyzer.sv -----
// A newline request passes through the input register and then the result register, whose
// output drives m_valid; the result is loaded when the newline leaves the input register.
// Throughput: one character per cycle; a newline waits in the input register only while
// an earlier result is still held by a low m_ready. Other characters never wait.
// Reset (aresetn low, synchronous) empties both registers and clears the line state.
// Top level of the IPv4 CIDR text analyzer; depends on cidr_pkg, cidr_line_acc and
// cidr_result_dec.
module ipv4_cidr_text_analyzer #(
    parameter int MAX_LINE_CHARS = cidr_pkg::MAX_LINE_CHARS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [cidr_pkg::CHAR_W-1:0]   s_char_code,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [3:0]                    m_status,
    output logic [cidr_pkg::ADDR_W-1:0]   m_address,
    output logic [cidr_pkg::PREFIX_W-1:0] m_prefix_len,
    output logic [cidr_pkg::ADDR_W-1:0]   m_network_addr,
    output logic [cidr_pkg::ADDR_W-1:0]   m_host_addr,
    output logic [2:0]                    m_addr_class,
    output logic [2:0]                    m_addr_type
);
    import cidr_pkg::*;

    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                m_valid_reg;
    result_t             res_reg;
    result_t             res_next;
    line_state_t         line_state;
    logic                is_nl;
    logic                out_free;
    logic                in_adv;

    // The held character moves on unless it is a newline facing a full result register.
    assign is_nl    = (in_char_reg == CHAR_NL);
    assign out_free = !m_valid_reg || m_ready;
    assign in_adv   = in_valid_reg && (!is_nl || out_free);
    assign s_ready  = !in_valid_reg || in_adv;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    cidr_line_acc u_acc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (in_adv),
        .char_code  (in_char_reg),
        .line_state (line_state)
    );

    cidr_result_dec #(
        .MAX_LINE_CHARS (MAX_LINE_CHARS)
    ) u_dec (
        .line_state (line_state),
        .result     (res_next)
    );

    // Result register, loaded when a newline leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_adv && is_nl) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && is_nl) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = res_reg.status;
    assign m_address      = res_reg.address;
    assign m_prefix_len   = res_reg.prefix_len;
    assign m_network_addr = res_reg.network_addr;
    assign m_host_addr    = res_reg.host_addr;
    assign m_addr_class   = res_reg.addr_class;
    assign m_addr_type    = res_reg.addr_type;

endmodule

// ----- design/cidr_checker.sv -----
// Port-level checker for the IPv4 CIDR text analyzer, bound to the top level.
// Depends on cidr_pkg for the result codes.
module cidr_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [3:0]                    m_status,
    input logic [cidr_pkg::ADDR_W-1:0]   m_address,
    input logic [cidr_pkg::PREFIX_W-1:0] m_prefix_len,
    input logic [cidr_pkg::ADDR_W-1:0]   m_network_addr,
    input logic [cidr_pkg::ADDR_W-1:0]   m_host_addr,
    input logic [2:0]                    m_addr_class,
    input logic [2:0]                    m_addr_type
);
    import cidr_pkg::*;

    // A stalled result request holds its valid, status, address, prefix, class and type.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_address)
            && $stable(m_prefix_len) && $stable(m_addr_class) && $stable(m_addr_type))
        else $error("result request changed while stalled");

    // A failed line carries a zero payload beside its status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_address == '0 && m_prefix_len == '0
            && m_network_addr == '0 && m_host_addr == '0
            && m_addr_class == CLASS_A && m_addr_type == TYPE_PUBLIC)
        else $error("failed line has a nonzero payload");

    // Network and host parts split the address without overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_network_addr | m_host_addr) == m_address
            && (m_network_addr & m_host_addr) == '0)
        else $error("network and host parts do not split the address");

    // An accepted line never reports a prefix beyond 32 or an unknown status.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_prefix_len <= 6'd32 && m_status <= ST_PREFIX)
        else $error("prefix or status out of range");

    // On an ok line, the class is none and the type localhost exactly when the first octet is 127.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |->
            (m_address[31:24] == 8'd127) == (m_addr_class == CLASS_NONE)
            && (m_address[31:24] == 8'd127) == (m_addr_type == TYPE_LOCALHOST))
        else $error("loopback class or type mismatch");

endmodule

bind ipv4_cidr_text_analyzer cidr_checker u_cidr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_address      (m_address),
    .m_prefix_len   (m_prefix_len),
    .m_network_addr (m_network_addr),
    .m_host_addr    (m_host_addr),
    .m_addr_class   (m_addr_class),
    .m_addr_type    (m_addr_type)
);
